/* hw/rtl/omni_wheel_speed_mixer_defines.svh */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer assertion macros
// Clocked, reset-qualified property checks shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef OMNI_WHEEL_SPEED_MIXER_DEFINES_SVH
`define OMNI_WHEEL_SPEED_MIXER_DEFINES_SVH

// property checked on every rising clk edge outside reset
`define OWSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define OWSM_ASSERT_NEVER(lbl, expr, msg) \
  `OWSM_ASSERT(lbl, !(expr), msg)

`endif

/* hw/rtl/owsm_pkg.sv */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer package
// Widths, register indexes, arithmetic constants and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package owsm_pkg;

  localparam int JOY_W      = 8;
  localparam int COEF_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int NUM_WHEELS = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // rounded axis in units of ten: -10..10 signed, magnitude 0..10
  localparam int AXIS_Q_W = 5;
  localparam int AXIS_M_W = 4;
  // wheel sums of tens-scaled axes: |sum| <= 655360
  localparam int SUM_W    = 21;
  localparam int MAG_W    = 20;
  localparam int TPROD_W  = 20;
  localparam int NUM_W    = MAG_W + SPEED_W;

  // axis rounding: saturate to 100, then (m + 4) / 10 via reciprocal
  localparam int SAT_W          = 7;
  localparam int ROUND_PROD_W   = 14;
  localparam int ROUND_SHIFT    = 10;
  localparam logic [SAT_W-1:0] JOY_SAT     = 7'd100;
  localparam logic [SAT_W-1:0] ROUND_BIAS  = 7'd4;
  localparam logic [SAT_W-1:0] ROUND_RECIP = 7'd103;

  // target / 10: exact for products below 2**22
  localparam int RECIP10_W     = 20;
  localparam int RECIP10_SHIFT = 23;
  localparam logic [RECIP10_W-1:0] RECIP10 = 20'd838861;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_W1_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W1_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W2_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W2_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W3_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W3_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd6;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][COEF_W-1:0] coef_x;
    logic [NUM_WHEELS-1:0][COEF_W-1:0] coef_y;
    logic [SPEED_W-1:0]                max_speed;
  } owsm_cfg_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]                 max_mag;
    logic [SPEED_W-1:0]               target;
    logic [NUM_WHEELS-1:0]            rev;
    logic                             stopped;
    logic                             fault;
  } owsm_entry_t;

endpackage

`default_nettype wire

/* hw/rtl/owsm_in_if.sv */
// ---------------------------------------------------------------------------
// Joystick input channel
// Valid/ready channel carrying one joystick x,y sample per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface owsm_in_if;
  import owsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [JOY_W-1:0] joy_x;
  logic signed [JOY_W-1:0] joy_y;

  modport source (output valid, output joy_x, output joy_y, input ready);
  modport sink   (input valid, input joy_x, input joy_y, output ready);
endinterface

`default_nettype wire

/* hw/rtl/owsm_out_if.sv */
// ---------------------------------------------------------------------------
// Wheel speed output channel
// Valid/ready channel carrying three wheel speeds and status per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface owsm_out_if;
  import owsm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_w1;
  logic [SPEED_W-1:0] speed_w2;
  logic [SPEED_W-1:0] speed_w3;
  logic               reverse_w1;
  logic               reverse_w2;
  logic               reverse_w3;
  logic               stopped;
  logic               divide_fault;

  modport source (
    output valid, output speed_w1, output speed_w2, output speed_w3,
    output reverse_w1, output reverse_w2, output reverse_w3,
    output stopped, output divide_fault, input ready
  );
  modport sink (
    input valid, input speed_w1, input speed_w2, input speed_w3,
    input reverse_w1, input reverse_w2, input reverse_w3,
    input stopped, input divide_fault, output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/omni_wheel_speed_mixer.sv */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer
// Three-wheel omni drive inverse kinematics: joystick x,y to wheel speeds.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : one joystick sample (joy_x, joy_y, percent) per transaction.
//   out_if : three wheel speed magnitudes, direction bits, stopped and
//            divide_fault flags, one result transaction per input.
//   cfg_*  : write-only register port; cfg_we with cfg_index 0..5 loads the
//            Q4.12 wheel weights, index 6 loads max_speed, index 7 is ignored.
//            Write only while no transaction is in flight.
// Path: an accepted sample passes three classifier stages, the entry
//   queue, the scaling multiply, sixteen divider stages (one quotient bit
//   each) and the output register before out_if.valid rises.
// Throughput: one transaction per cycle unless stalled (pipelined divider).
// Reset: rst_n low clears the configuration registers to zero and empties
//   the pipelines and the entry queue.
// Stall: while out_if.ready is low with a result waiting, the divider
//   pipeline holds; the classifier keeps accepting until the entry queue is
//   full and its last stage holds a transaction, then in_if.ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_speed_mixer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  owsm_in_if.sink                             in_if,
  owsm_out_if.source                          out_if,
  input  wire logic                           cfg_we,
  input  wire logic [owsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [owsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import owsm_pkg::*;

  owsm_cfg_t   cfg_r, cfg_nxt;
  logic        push, pop, q_full, q_empty;
  owsm_entry_t push_data, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COEF_W1_X: cfg_nxt.coef_x[0]  = cfg_wdata;
        REG_COEF_W1_Y: cfg_nxt.coef_y[0]  = cfg_wdata;
        REG_COEF_W2_X: cfg_nxt.coef_x[1]  = cfg_wdata;
        REG_COEF_W2_Y: cfg_nxt.coef_y[1]  = cfg_wdata;
        REG_COEF_W3_X: cfg_nxt.coef_x[2]  = cfg_wdata;
        REG_COEF_W3_Y: cfg_nxt.coef_y[2]  = cfg_wdata;
        REG_MAX_SPEED: cfg_nxt.max_speed  = cfg_wdata;
        default:       cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  owsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  owsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  owsm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

/* hw/rtl/owsm_front.sv */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer front end
// Rounds the axes, mixes them into wheel sums and classifies each sample
// (stop, zero divisor, direction) into a queue entry. Three stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owsm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  owsm_in_if.sink                  in_if,
  input  wire owsm_pkg::owsm_cfg_t cfg,
  input  wire logic                q_full,
  output logic                     push,
  output owsm_pkg::owsm_entry_t    push_data
);
  import owsm_pkg::*;

  function automatic logic [AXIS_M_W-1:0] axis_tens(input logic [JOY_W-1:0] v);
    logic [JOY_W-1:0]        m;
    logic [SAT_W-1:0]        s;
    logic [ROUND_PROD_W-1:0] p;
    m = v[JOY_W-1] ? JOY_W'(~v + 1'b1) : v;
    s = (m > JOY_W'(JOY_SAT)) ? JOY_SAT : m[SAT_W-1:0];
    p = ROUND_PROD_W'(SAT_W'(s + ROUND_BIAS)) * ROUND_PROD_W'(ROUND_RECIP);
    return AXIS_M_W'(p >> ROUND_SHIFT);
  endfunction

  localparam int TP_W = TPROD_W + RECIP10_W;

  logic fe;

  // stage 1: rounded axes
  logic                       f1_v_r;
  logic signed [AXIS_Q_W-1:0] f1_qx_r, f1_qy_r;
  logic [AXIS_M_W-1:0]        f1_qm_r;
  logic                       f1_stop_r;
  logic [AXIS_M_W-1:0]        ax, ay;
  logic signed [AXIS_Q_W-1:0] qx_nxt, qy_nxt;

  // stage 2: wheel sums and speed product
  logic                    f2_v_r;
  logic signed [SUM_W-1:0] f2_sum_r [NUM_WHEELS];
  logic [TPROD_W-1:0]      f2_tprod_r;
  logic                    f2_stop_r;
  logic signed [SUM_W-1:0] sum_nxt [NUM_WHEELS];

  // stage 3: classified entry
  logic        f3_v_r;
  owsm_entry_t f3_entry_r;
  owsm_entry_t entry_nxt;
  logic [TP_W-1:0] tp;

  assign fe          = !f3_v_r || !q_full;
  assign in_if.ready = fe;
  assign push        = f3_v_r && !q_full;
  assign push_data   = f3_entry_r;

  always_comb begin
    ax     = axis_tens(in_if.joy_x);
    ay     = axis_tens(in_if.joy_y);
    qx_nxt = signed'({1'b0, ax});
    qy_nxt = signed'({1'b0, ay});
    if (in_if.joy_x[JOY_W-1]) begin
      qx_nxt = -qx_nxt;
    end
    if (in_if.joy_y[JOY_W-1]) begin
      qy_nxt = -qy_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum_nxt[i] = SUM_W'(f1_qx_r) * SUM_W'($signed(cfg.coef_x[i]))
                 + SUM_W'(f1_qy_r) * SUM_W'($signed(cfg.coef_y[i]));
    end
  end

  always_comb begin
    entry_nxt = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      entry_nxt.mag[i] = f2_sum_r[i][SUM_W-1] ? MAG_W'(-f2_sum_r[i])
                                              : MAG_W'(f2_sum_r[i]);
      entry_nxt.rev[i] = !f2_stop_r && (f2_sum_r[i][SUM_W-1] || (f2_sum_r[i] == '0));
    end
    entry_nxt.max_mag = entry_nxt.mag[0];
    for (int i = 1; i < NUM_WHEELS; i++) begin
      if (entry_nxt.mag[i] > entry_nxt.max_mag) begin
        entry_nxt.max_mag = entry_nxt.mag[i];
      end
    end
    tp                = TP_W'(f2_tprod_r) * TP_W'(RECIP10);
    entry_nxt.target  = SPEED_W'(tp >> RECIP10_SHIFT);
    entry_nxt.stopped = f2_stop_r;
    entry_nxt.fault   = !f2_stop_r && (entry_nxt.max_mag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= in_if.valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f1_qx_r    <= qx_nxt;
      f1_qy_r    <= qy_nxt;
      f1_qm_r    <= (ax > ay) ? ax : ay;
      f1_stop_r  <= (ax == '0) && (ay == '0);
      f2_sum_r   <= sum_nxt;
      f2_tprod_r <= TPROD_W'(f1_qm_r) * TPROD_W'(cfg.max_speed);
      f2_stop_r  <= f1_stop_r;
      f3_entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/owsm_queue.sv */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer entry queue
// Small register FIFO decoupling the classifier from the divider pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "omni_wheel_speed_mixer_defines.svh"

module owsm_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire owsm_pkg::owsm_entry_t push_data,
  input  wire logic                  pop,
  output owsm_pkg::owsm_entry_t      head,
  output logic                       full,
  output logic                       empty
);
  import owsm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  owsm_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `OWSM_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
  `OWSM_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")
  `OWSM_ASSERT(a_count_up, push && !pop |=> count_r == $past(count_r) + 1'b1, "count lost a push")

endmodule

`default_nettype wire

/* hw/rtl/owsm_back.sv */
// ---------------------------------------------------------------------------
// Omni wheel speed mixer back end
// Scales each wheel magnitude by the target and divides by the largest
// magnitude in a bit-per-stage pipelined divider, then drives the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "omni_wheel_speed_mixer_defines.svh"

module owsm_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire owsm_pkg::owsm_entry_t q_head,
  output logic                       pop,
  owsm_out_if.source                 out_if
);
  import owsm_pkg::*;

  localparam int DIV_STEPS = SPEED_W;

  typedef struct packed {
    logic [MAG_W-1:0]      div;
    logic [NUM_WHEELS-1:0] rev;
    logic                  stopped;
    logic                  fault;
  } owsm_meta_t;

  logic be;

  logic               v_r     [DIV_STEPS+1];
  owsm_meta_t         meta_r  [DIV_STEPS+1];
  logic [MAG_W-1:0]   rem_r   [DIV_STEPS+1][NUM_WHEELS];
  logic [SPEED_W-1:0] nlo_r   [DIV_STEPS+1][NUM_WHEELS];
  logic [SPEED_W-1:0] quo_r   [DIV_STEPS+1][NUM_WHEELS];
  logic [MAG_W-1:0]   rem_nxt [DIV_STEPS+1][NUM_WHEELS];
  logic [SPEED_W-1:0] nlo_nxt [DIV_STEPS+1][NUM_WHEELS];
  logic [SPEED_W-1:0] quo_nxt [DIV_STEPS+1][NUM_WHEELS];
  logic [NUM_W-1:0]   num     [NUM_WHEELS];
  logic [MAG_W:0]     trial   [DIV_STEPS+1][NUM_WHEELS];
  logic               ge      [DIV_STEPS+1][NUM_WHEELS];

  logic                  out_valid_r;
  logic [SPEED_W-1:0]    spd_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] rev_r;
  logic                  stop_r;
  logic                  fault_r;

  assign be  = !out_valid_r || out_if.ready;
  assign pop = be && !q_empty;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      num[i]        = NUM_W'(q_head.mag[i]) * NUM_W'(q_head.target);
      rem_nxt[0][i] = num[i][NUM_W-1:SPEED_W];
      nlo_nxt[0][i] = num[i][SPEED_W-1:0];
      quo_nxt[0][i] = '0;
      trial[0][i]   = '0;
      ge[0][i]      = 1'b0;
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        trial[s][i]   = {rem_r[s-1][i], nlo_r[s-1][i][SPEED_W-1]};
        ge[s][i]      = trial[s][i] >= {1'b0, meta_r[s-1].div};
        rem_nxt[s][i] = ge[s][i] ? MAG_W'(trial[s][i] - {1'b0, meta_r[s-1].div})
                                 : trial[s][i][MAG_W-1:0];
        nlo_nxt[s][i] = {nlo_r[s-1][i][SPEED_W-2:0], 1'b0};
        quo_nxt[s][i] = {quo_r[s-1][i][SPEED_W-2:0], ge[s][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STEPS; s++) begin
        v_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (be) begin
      v_r[0] <= pop;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        v_r[s] <= v_r[s-1];
      end
      out_valid_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      meta_r[0].div     <= q_head.max_mag;
      meta_r[0].rev     <= q_head.rev;
      meta_r[0].stopped <= q_head.stopped;
      meta_r[0].fault   <= q_head.fault;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        meta_r[s] <= meta_r[s-1];
      end
      rem_r <= rem_nxt;
      nlo_r <= nlo_nxt;
      quo_r <= quo_nxt;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        spd_r[i] <= (meta_r[DIV_STEPS].stopped || meta_r[DIV_STEPS].fault)
                    ? '0 : quo_r[DIV_STEPS][i];
      end
      rev_r   <= meta_r[DIV_STEPS].rev;
      stop_r  <= meta_r[DIV_STEPS].stopped;
      fault_r <= meta_r[DIV_STEPS].fault;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.speed_w1     = spd_r[0];
  assign out_if.speed_w2     = spd_r[1];
  assign out_if.speed_w3     = spd_r[2];
  assign out_if.reverse_w1   = rev_r[0];
  assign out_if.reverse_w2   = rev_r[1];
  assign out_if.reverse_w3   = rev_r[2];
  assign out_if.stopped      = stop_r;
  assign out_if.divide_fault = fault_r;

  `OWSM_ASSERT_NEVER(a_flags_excl, out_valid_r && stop_r && fault_r, "stop and fault together")
  `OWSM_ASSERT(a_stop_quiet, out_valid_r && stop_r |-> rev_r == '0 && spd_r[0] == '0 && spd_r[1] == '0 && spd_r[2] == '0, "stopped result not quiet")
  `OWSM_ASSERT(a_drain, v_r[DIV_STEPS] && be |=> out_valid_r, "divider result dropped")

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Omni wheel speed mixer testbench
// Drives joystick samples through a table of directed rows and then several
// randomized register settings. Every result transaction is checked against
// an internal kinematics predictor or a typed value. Both channel sides
// stall at random, and one long output hold-off backs up the pipeline.
// ---------------------------------------------------------------------------
module testbench;
  import owsm_pkg::*;

  localparam int PIPE_LATENCY   = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 450;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 310;
  localparam int NUM_ROWS       = 42;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_w1, speed_w2, speed_w3;
    logic reverse_w1, reverse_w2, reverse_w3, stopped, divide_fault;
  } wheel_cmd_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    logic signed [JOY_W-1:0] jx;
    logic signed [JOY_W-1:0] jy;
    bit                      typed;
    wheel_cmd_t              want;
  } stim_row_t;

  localparam wheel_cmd_t CMD_NONE  = '0;
  localparam wheel_cmd_t CMD_STOP  = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam wheel_cmd_t CMD_FAULT = '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam wheel_cmd_t CMD_X_FWD = '{16'd1000, 16'd500, 16'd500,
                                       1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam wheel_cmd_t CMD_FULL_REV = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam wheel_cmd_t CMD_FULL_FWD = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd0, 8'sd0, 1'b1, CMD_STOP},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd100, 8'sd100, 1'b1, CMD_FAULT},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sh80, 8'sh7F, 1'b1, CMD_FAULT},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd5, -8'sd5, 1'b1, CMD_STOP},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd6, 8'sd0, 1'b1, CMD_FAULT},
    '{ROW_CFG, REG_COEF_W1_X, 16'h1000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W1_Y, 16'h0000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_X, 16'hF800, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_Y, 16'h0DDB, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_X, 16'hF800, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_Y, 16'hF225, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_MAX_SPEED, 16'd1000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_UNUSED, 16'hFFFF, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd100, 8'sd0, 1'b1, CMD_X_FWD},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd100, -8'sd100, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sh7F, 8'sh80, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd15, -8'sd15, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd16, -8'sd16, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd5, 8'sd5, 1'b1, CMD_STOP},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd6, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd0, -8'sd100, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W1_X, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W1_Y, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_X, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_Y, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_X, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_Y, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_MAX_SPEED, 16'hFFFF, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd100, 8'sd100, 1'b1, CMD_FULL_REV},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd100, -8'sd100, 1'b1, CMD_FAULT},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd100, 8'sd0, 1'b1, CMD_FULL_FWD},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd45, 8'sd44, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W1_X, 16'h7FFF, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W1_Y, 16'h0000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_X, 16'h0000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W2_Y, 16'h7FFF, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_X, 16'h7FFF, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_COEF_W3_Y, 16'h8000, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_CFG, REG_MAX_SPEED, 16'd0, 8'sd0, 8'sd0, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd100, 8'sd50, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, -8'sd30, 8'sd70, 1'b0, CMD_NONE},
    '{ROW_ITEM, REG_COEF_W1_X, 16'd0, 8'sd0, -8'sd10, 1'b0, CMD_NONE}
  };

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  owsm_in_if  in_ch ();
  owsm_out_if out_ch ();

  omni_wheel_speed_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register shadow used by the predictor
  logic signed [COEF_W-1:0] wheel_coef [2*NUM_WHEELS];
  logic [SPEED_W-1:0]       top_speed;

  wheel_cmd_t expected_cmds [$];
  int  mismatches   = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  sender_may_idle = 1'b1;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int round_pct(input logic signed [JOY_W-1:0] raw);
    int mag;
    int q;
    mag = (raw < 0) ? -int'(raw) : int'(raw);
    if (mag > 100) mag = 100;
    q = mag / 10;
    if (mag % 10 > 5) q++;
    return (raw < 0) ? -q * 10 : q * 10;
  endfunction

  function automatic wheel_cmd_t predict_cmd(input logic signed [JOY_W-1:0] jx,
                                             input logic signed [JOY_W-1:0] jy);
    int         ax;
    int         ay;
    longint     sum [NUM_WHEELS];
    longint     mag [NUM_WHEELS];
    longint     mag_max;
    longint     pct;
    longint     target;
    longint     spd [NUM_WHEELS];
    logic       rev [NUM_WHEELS];
    wheel_cmd_t r;
    r = '0;
    ax = round_pct(jx);
    ay = round_pct(jy);
    if (ax == 0 && ay == 0) begin
      r.stopped = 1'b1;
      return r;
    end
    mag_max = 0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum[i] = longint'(ax) * longint'(wheel_coef[2*i]) +
               longint'(ay) * longint'(wheel_coef[2*i+1]);
      mag[i] = (sum[i] < 0) ? -sum[i] : sum[i];
      if (mag[i] > mag_max) mag_max = mag[i];
      rev[i] = (sum[i] <= 0);
      spd[i] = 0;
    end
    pct = (ax < 0) ? -ax : ax;
    if (((ay < 0) ? -ay : ay) > pct) pct = (ay < 0) ? -ay : ay;
    target = pct * longint'(top_speed) / 100;
    if (mag_max == 0) r.divide_fault = 1'b1;
    else for (int i = 0; i < NUM_WHEELS; i++) spd[i] = mag[i] * target / mag_max;
    r.speed_w1   = spd[0][SPEED_W-1:0];
    r.speed_w2   = spd[1][SPEED_W-1:0];
    r.speed_w3   = spd[2][SPEED_W-1:0];
    r.reverse_w1 = rev[0];
    r.reverse_w2 = rev[1];
    r.reverse_w3 = rev[2];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [JOY_W-1:0] pick_joy();
    int r;
    int v;
    r = $urandom_range(0, 19);
    if (r < 2) return JOY_W'($urandom);
    if (r < 5) return '0;
    if (r < 10) begin
      // values next to a rounding tie
      v = $urandom_range(0, 9) * 10 + $urandom_range(4, 6);
      return JOY_W'(($urandom_range(0, 1) != 0) ? -v : v);
    end
    v = $urandom_range(0, 200);
    return JOY_W'(v - 100);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < REG_MAX_SPEED) wheel_coef[idx] = val;
    else if (idx == REG_MAX_SPEED) top_speed = val;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_sample(input logic [JOY_W-1:0] jx, input logic [JOY_W-1:0] jy,
                             input bit typed, input wheel_cmd_t want);
    @(negedge clk);
    while (sender_may_idle && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.joy_x <= jx;
    in_ch.joy_y <= jy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_cmds.push_back(typed ? want : predict_cmd(jx, jy));
  endtask

  // result checker
  always @(posedge clk) begin
    wheel_cmd_t got;
    wheel_cmd_t exp_cmd;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.speed_w1, out_ch.speed_w2, out_ch.speed_w3,
              out_ch.reverse_w1, out_ch.reverse_w2, out_ch.reverse_w3,
              out_ch.stopped, out_ch.divide_fault};
      results_seen++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result transaction: spd %0d/%0d/%0d", $realtime,
                   got.speed_w1, got.speed_w2, got.speed_w3);
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (got !== exp_cmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] mismatch: exp spd %0d/%0d/%0d rev %b%b%b stop %b flt %b,",
                      " got spd %0d/%0d/%0d rev %b%b%b stop %b flt %b"}, $realtime,
                     exp_cmd.speed_w1, exp_cmd.speed_w2, exp_cmd.speed_w3,
                     exp_cmd.reverse_w1, exp_cmd.reverse_w2, exp_cmd.reverse_w3,
                     exp_cmd.stopped, exp_cmd.divide_fault,
                     got.speed_w1, got.speed_w2, got.speed_w3,
                     got.reverse_w1, got.reverse_w2, got.reverse_w3,
                     got.stopped, got.divide_fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, a clean stretch and one long hold-off
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (results_seen >= 1000 && results_seen < 1300) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 22);
      end
    end
  end

  initial begin : stimulus
    logic [JOY_W-1:0] jx;
    logic [JOY_W-1:0] jy;
    logic [COEF_W-1:0] cval;
    bit pending;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.joy_x = '0;
    in_ch.joy_y = '0;
    for (int i = 0; i < 2 * NUM_WHEELS; i++) wheel_coef[i] = '0;
    top_speed = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    pending = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (pending) drain_pipeline();
        pending = 1'b0;
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_sample(directed_rows[i].jx, directed_rows[i].jy,
                    directed_rows[i].typed, directed_rows[i].want);
        pending = 1'b1;
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      for (int i = 0; i < 2 * NUM_WHEELS; i++) begin
        cval = pick_coef();
        if (p == 3 && i % 2 == 0) cval = '0;
        write_reg(CFG_IDX_W'(i), cval);
      end
      case (p)
        1: write_reg(REG_MAX_SPEED, 16'hFFFF);
        2: write_reg(REG_MAX_SPEED, 16'h0000);
        default: write_reg(REG_MAX_SPEED, ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                                        : SPEED_W'($urandom));
      endcase
      if (p == 4) write_reg(REG_UNUSED, 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_may_idle = !(p * PHASE_ITEMS + n >= 500 && p * PHASE_ITEMS + n < 900);
        if ($urandom_range(0, 19) == 0) begin
          jx = '0;
          jy = '0;
        end else begin
          jx = pick_joy();
          jy = pick_joy();
        end
        send_sample(jx, jy, 1'b0, CMD_NONE);
      end
    end

    drain_pipeline();
    if (mismatches == 0 && expected_cmds.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
